>>> src/isfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared types and constants for the inverter status frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

   localparam int FRAME_LEN = 27;
   localparam int LAST_POS  = FRAME_LEN - 1;

   typedef enum logic [1:0] {
      PHASE_MAGIC = 2'd0,
      PHASE_CODE  = 2'd1,
      PHASE_BODY  = 2'd2
   } phase_type;

   localparam logic REG_HEADER_MAGIC = 1'b0;
   localparam logic REG_STATUS_CODE  = 1'b1;

   typedef struct packed {
      logic [7:0] header_magic;
      logic [7:0] status_code;
   } csr_type;

   typedef struct packed {
      logic [31:0] device_id;
      logic [31:0] energy_bits;
      logic [15:0] dc_volts_centi;
      logic [15:0] dc_amps_centi;
      logic [15:0] ac_volts_centi;
      logic [15:0] ac_amps_centi;
      logic [7:0]  state_byte;
      logic [7:0]  temperature_byte;
      logic        sum_ok;
   } frame_type;

endpackage

>>> src/isfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_front
// Header hunt, byte collection and checksum; hands a finished frame to the
// queue on its last byte.
// ----------------------------------------------------------------------------
module isfp_front import isfp_pkg::*; #(
   parameter int CHECKSUM_SPAN = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    cfg,
   input  logic       in_valid,
   input  logic [7:0] in_data,
   output logic       in_ready,
   input  logic       q_full,
   output logic       push_valid,
   output frame_type  push_frame
);

   localparam int CHECK_IDX = (CHECKSUM_SPAN < LAST_POS) ? CHECKSUM_SPAN : 0;

   phase_type  phase_ff, phase_in;
   logic [4:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] frame_ff [LAST_POS];
   logic       accept;
   logic [7:0] check_byte;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_MAGIC;
         pos_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PHASE_BODY && pos_ff < 5'(LAST_POS)) begin
         frame_ff[pos_ff] <= in_data;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      push_valid = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PHASE_CODE: begin
               if (in_data == cfg.status_code) begin
                  sum_in   = sum_ff + in_data;
                  pos_in   = 5'd2;
                  phase_in = PHASE_BODY;
               end else if (in_data == cfg.header_magic) begin
                  sum_in   = in_data;
                  pos_in   = 5'd1;
                  phase_in = PHASE_CODE;
               end else begin
                  sum_in   = '0;
                  pos_in   = '0;
                  phase_in = PHASE_MAGIC;
               end
            end
            PHASE_BODY: begin
               if (pos_ff < 5'(CHECKSUM_SPAN)) begin
                  sum_in = sum_ff + in_data;
               end
               if (pos_ff == 5'(LAST_POS)) begin
                  push_valid = 1'b1;
                  sum_in     = '0;
                  pos_in     = '0;
                  phase_in   = PHASE_MAGIC;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            default: begin
               phase_in = PHASE_MAGIC;
               if (in_data == cfg.header_magic) begin
                  sum_in   = in_data;
                  pos_in   = 5'd1;
                  phase_in = PHASE_CODE;
               end
            end
         endcase
      end
   end

   // check byte is the current byte when it is the last one of the frame
   assign check_byte = (CHECKSUM_SPAN == LAST_POS) ? in_data : frame_ff[CHECK_IDX];

   always_comb begin
      push_frame.device_id        = {frame_ff[6], frame_ff[7], frame_ff[8], frame_ff[9]};
      push_frame.energy_bits      = {frame_ff[10], frame_ff[11], frame_ff[12], frame_ff[13]};
      push_frame.dc_volts_centi   = {frame_ff[15], frame_ff[16]};
      push_frame.dc_amps_centi    = {frame_ff[17], frame_ff[18]};
      push_frame.ac_volts_centi   = {frame_ff[19], frame_ff[20]};
      push_frame.ac_amps_centi    = {frame_ff[21], frame_ff[22]};
      push_frame.state_byte       = frame_ff[25];
      push_frame.temperature_byte = in_data;
      push_frame.sum_ok           = (sum_ff == check_byte);
   end

endmodule

>>> src/isfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_queue
// Two-entry frame queue between the byte collector and the output stage.
// ----------------------------------------------------------------------------
module isfp_queue import isfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  frame_type push_frame,
   output logic      full,
   output logic      pop_valid,
   input  logic      pop_ready,
   output frame_type pop_frame
);

   frame_type  slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_frame = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

>>> src/isfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_back
// Output stage: forms the power products and holds the result transaction.
// ----------------------------------------------------------------------------
module isfp_back import isfp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  frame_type    in_frame,
   output logic         in_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [207:0] rsp_tdata,
   output logic         rsp_tuser
);

   logic         valid_ff, valid_in;
   logic [207:0] data_ff;
   logic         flag_ff;
   logic         load;
   logic [31:0]  dc_product;
   logic [31:0]  ac_product;

   assign in_ready   = !valid_ff || rsp_tready;
   assign load       = in_valid && in_ready;
   assign dc_product = 32'(in_frame.dc_volts_centi) * 32'(in_frame.dc_amps_centi);
   assign ac_product = 32'(in_frame.ac_volts_centi) * 32'(in_frame.ac_amps_centi);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {in_frame.temperature_byte, in_frame.state_byte,
                     ac_product, in_frame.ac_amps_centi, in_frame.ac_volts_centi,
                     dc_product, in_frame.dc_amps_centi, in_frame.dc_volts_centi,
                     in_frame.energy_bits, in_frame.device_id};
         flag_ff <= in_frame.sum_ok;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = flag_ff;

endmodule

>>> src/inverter_status_frame_parser.sv
`timescale 1ns / 1ps
// Path: a frame's last accepted byte pushes it into a queue slot, then the output register offers it on rsp.
// Throughput: one byte per cycle while the queue is not full, set by the header/collect loop;
// a frame takes 27 bytes, so at most one result per 27 accepted bytes.
// Reset: synchronous; clears the hunt state, queue, output stage and registers.
// ----------------------------------------------------------------------------
// inverter_status_frame_parser
// Byte-stream parser for inverter status frames with checksum and power.
// ----------------------------------------------------------------------------
module inverter_status_frame_parser import isfp_pkg::*; #(
   parameter int CHECKSUM_SPAN = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] device_id, [63:32] energy_bits, [79:64] dc_volts_centi,
   // [95:80] dc_amps_centi, [127:96] dc_power_product, [143:128] ac_volts_centi,
   // [159:144] ac_amps_centi, [191:160] ac_power_product, [199:192] state_byte,
   // [207:200] temperature_byte
   output logic [207:0] rsp_tdata,
   output logic         rsp_tuser,   // [0] sum_ok
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   csr_type   csr_ff;
   logic      csr_write;
   logic      push_valid;
   frame_type push_frame;
   logic      q_full;
   logic      pop_valid;
   logic      pop_ready;
   frame_type pop_frame;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_HEADER_MAGIC: csr_ff.header_magic <= csr_pwdata[7:0];
            REG_STATUS_CODE:  csr_ff.status_code  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_HEADER_MAGIC: csr_prdata = {24'd0, csr_ff.header_magic};
         REG_STATUS_CODE:  csr_prdata = {24'd0, csr_ff.status_code};
         default:          csr_prdata = '0;
      endcase
   end

   isfp_front #(
      .CHECKSUM_SPAN (CHECKSUM_SPAN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (csr_ff),
      .in_valid   (req_tvalid),
      .in_data    (req_tdata),
      .in_ready   (req_tready),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_frame (push_frame)
   );

   isfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_frame (push_frame),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   isfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pop_valid),
      .in_frame   (pop_frame),
      .in_ready   (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_full))
      else $error("frame pushed into a full queue");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && !rsp_tvalid) |=> rsp_tvalid)
      else $error("queued frame not moved to the output stage");

   a_idle_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

>>> verif/tb_inverter_status_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverter_status_frame_parser
// Self-checking bench: a directed table of frames and broken headers, then
// random frames, header breaks and noise under several header settings. A
// local parser model, or a quoted table row, predicts every status record,
// which is compared field by field with each rsp transaction. Both stream
// sides idle at random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_inverter_status_frame_parser;
   import isfp_pkg::*;

   localparam int          CHECKSUM_SPAN = 14;
   localparam int          RANDOM_ITEMS  = 1300;
   localparam int          MIN_FRAMES    = 48;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          HOLD_CYCLES   = 800;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   localparam logic [2:0] ADDR_MAGIC = 3'(4 * int'(REG_HEADER_MAGIC));
   localparam logic [2:0] ADDR_CODE  = 3'(4 * int'(REG_STATUS_CODE));

   // MSB first, so {rsp_tuser, rsp_tdata} maps straight onto it
   typedef struct packed {
      logic        sum_ok;
      logic [7:0]  temperature_byte;
      logic [7:0]  state_byte;
      logic [31:0] ac_power_product;
      logic [15:0] ac_amps_centi;
      logic [15:0] ac_volts_centi;
      logic [31:0] dc_power_product;
      logic [15:0] dc_amps_centi;
      logic [15:0] dc_volts_centi;
      logic [31:0] energy_bits;
      logic [31:0] device_id;
   } status_rec_type;

   localparam status_rec_type ALL_ZERO_FRAME = '{sum_ok: 1'b1, default: '0};
   localparam status_rec_type ALL_ONES_FRAME = '{dc_power_product: 32'hFFFE_0001,
                                                ac_power_product: 32'hFFFE_0001,
                                                sum_ok: 1'b0, default: '1};

   typedef enum logic {ROW_SEND, ROW_WRITE} row_kind_type;
   typedef enum int {PACE_OPEN, PACE_COIN, PACE_COMB} pace_type;

   typedef struct {
      row_kind_type   kind;
      int             count;
      logic [2:0]     addr;
      logic [7:0]     value;
      bit             quoted;
      status_rec_type frame;
   } drow_type;

   drow_type directed_rows [19] = '{
      '{ROW_SEND,  27, ADDR_MAGIC, 8'h00, 1'b1, ALL_ZERO_FRAME},
      '{ROW_WRITE,  1, ADDR_MAGIC, 8'h55, 1'b0, ALL_ZERO_FRAME},
      '{ROW_WRITE,  1, ADDR_CODE,  8'hC3, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   1, ADDR_MAGIC, 8'hC3, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   1, ADDR_MAGIC, 8'h55, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   1, ADDR_MAGIC, 8'h12, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   2, ADDR_MAGIC, 8'h55, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   1, ADDR_MAGIC, 8'hC3, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,  12, ADDR_MAGIC, 8'h80, 1'b0, ALL_ZERO_FRAME},
      '{ROW_WRITE,  1, ADDR_MAGIC, 8'hFF, 1'b0, ALL_ZERO_FRAME},
      '{ROW_WRITE,  1, ADDR_CODE,  8'hFF, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,  13, ADDR_MAGIC, 8'h55, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,  27, ADDR_MAGIC, 8'hFF, 1'b1, ALL_ONES_FRAME},
      '{ROW_WRITE,  1, ADDR_MAGIC, 8'h00, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   1, ADDR_MAGIC, 8'h00, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   1, ADDR_MAGIC, 8'hFF, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,  12, ADDR_MAGIC, 8'h00, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,   1, ADDR_MAGIC, 8'hFF, 1'b0, ALL_ZERO_FRAME},
      '{ROW_SEND,  12, ADDR_MAGIC, 8'h00, 1'b0, ALL_ZERO_FRAME}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;      // [7:0] rx_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;              // device_id first, temperature_byte last
   logic         rsp_tuser;              // [0] sum_ok
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = 3'd0;
   logic [31:0]  csr_pwdata = 32'h0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // parser model state
   phase_type    hunt;
   int           fpos;
   logic [7:0]   fsum;
   logic [7:0]   fbytes [FRAME_LEN];
   logic [7:0]   magic_reg;
   logic [7:0]   code_reg;

   status_rec_type pending_frames [$];
   status_rec_type quoted_frames [$];
   int             frames_checked = 0;
   int             mismatches = 0;
   int unsigned    cycle_count = 0;
   int             burst_left = 0;
   bit             hold_request = 1'b0;

   inverter_status_frame_parser #(.CHECKSUM_SPAN(CHECKSUM_SPAN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] be16(input int i);
      return {fbytes[i], fbytes[i + 1]};
   endfunction

   function void parse_byte(input logic [7:0] b);
      status_rec_type r;
      if (hunt == PHASE_CODE) begin
         if (b == code_reg) begin
            fbytes[1] = b;
            if (1 < CHECKSUM_SPAN) fsum = fsum + b;
            fpos = 2;
            hunt = PHASE_BODY;
         end else if (b == magic_reg) begin
            fbytes[0] = b;
            fsum = b;
            fpos = 1;
         end else begin
            hunt = PHASE_MAGIC;
            fpos = 0;
            fsum = 8'h00;
         end
      end else if (hunt == PHASE_BODY) begin
         fbytes[fpos] = b;
         if (fpos < CHECKSUM_SPAN) fsum = fsum + b;
         if (fpos < LAST_POS) begin
            fpos++;
         end else begin
            r.device_id        = {be16(6), be16(8)};
            r.energy_bits      = {be16(10), be16(12)};
            r.dc_volts_centi   = be16(15);
            r.dc_amps_centi    = be16(17);
            r.dc_power_product = {16'h0, r.dc_volts_centi} * {16'h0, r.dc_amps_centi};
            r.ac_volts_centi   = be16(19);
            r.ac_amps_centi    = be16(21);
            r.ac_power_product = {16'h0, r.ac_volts_centi} * {16'h0, r.ac_amps_centi};
            r.state_byte       = fbytes[25];
            r.temperature_byte = fbytes[26];
            r.sum_ok           = (fsum == fbytes[CHECKSUM_SPAN % FRAME_LEN]);
            if (quoted_frames.size() != 0) r = quoted_frames.pop_front();
            pending_frames.push_back(r);
            hunt = PHASE_MAGIC;
            fpos = 0;
            fsum = 8'h00;
         end
      end else begin
         hunt = PHASE_MAGIC;
         if (b == magic_reg) begin
            fbytes[0] = b;
            fsum = b;
            fpos = 1;
            hunt = PHASE_CODE;
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : observe
      status_rec_type want, got;
      if (reset) begin
         hunt = PHASE_MAGIC;
         fpos = 0;
         fsum = 8'h00;
         magic_reg = 8'h00;
         code_reg = 8'h00;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_MAGIC) magic_reg = csr_pwdata[7:0];
            else if (csr_paddr == ADDR_CODE) code_reg = csr_pwdata[7:0];
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = status_rec_type'({rsp_tuser, rsp_tdata});
            if (pending_frames.size() == 0) begin
               $display("%0t ns: frame expected none actual device_id %h", $time,
                        got.device_id);
               mismatches++;
            end else begin
               want = pending_frames.pop_front();
               check_field("device_id", want.device_id, got.device_id);
               check_field("energy_bits", want.energy_bits, got.energy_bits);
               check_field("dc_volts_centi", 32'(want.dc_volts_centi),
                           32'(got.dc_volts_centi));
               check_field("dc_amps_centi", 32'(want.dc_amps_centi),
                           32'(got.dc_amps_centi));
               check_field("dc_power_product", want.dc_power_product,
                           got.dc_power_product);
               check_field("ac_volts_centi", 32'(want.ac_volts_centi),
                           32'(got.ac_volts_centi));
               check_field("ac_amps_centi", 32'(want.ac_amps_centi),
                           32'(got.ac_amps_centi));
               check_field("ac_power_product", want.ac_power_product,
                           got.ac_power_product);
               check_field("state_byte", 32'(want.state_byte), 32'(got.state_byte));
               check_field("temperature_byte", 32'(want.temperature_byte),
                           32'(got.temperature_byte));
               check_field("sum_ok", 32'(want.sum_ok), 32'(got.sum_ok));
            end
            frames_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver pacing; one long hold-off on request
   initial begin
      pace_type pace;
      int       span;
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            pace = pace_type'($urandom_range(0, 2));
            span = $urandom_range(8, 80);
            repeat (span) begin
               case (pace)
                  PACE_OPEN: rsp_tready <= 1'b1;
                  PACE_COIN: rsp_tready <= ($urandom_range(0, 1) == 1);
                  default:   rsp_tready <= (cycle_count % 3 != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_frame(input logic [7:0] m, input logic [7:0] c);
      logic [7:0] fb [FRAME_LEN];
      logic [7:0] acc;
      acc   = 8'h00;
      fb[0] = m;
      fb[1] = c;
      for (int i = 2; i < FRAME_LEN; i++) begin
         case ($urandom_range(0, 9))
            0:       fb[i] = 8'h00;
            1:       fb[i] = 8'hFF;
            default: fb[i] = 8'($urandom());
         endcase
      end
      for (int i = 0; i < CHECKSUM_SPAN; i++) acc = acc + fb[i];
      if ($urandom_range(0, 2) == 0) fb[CHECKSUM_SPAN] = acc;
      foreach (fb[i]) send_byte(fb[i]);
   endtask

   initial begin
      logic [7:0] m, c;
      int         phase_items, roll, n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (reset) @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_idle();
            csr_write(directed_rows[i].addr, directed_rows[i].value);
         end else begin
            if (directed_rows[i].quoted) begin
               wait_idle();
               quoted_frames.push_back(directed_rows[i].frame);
            end
            repeat (directed_rows[i].count) send_byte(directed_rows[i].value);
         end
      end

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin m = 8'h00; c = 8'hFF; end
            1: begin m = 8'hFF; c = 8'h00; end
            3: begin m = 8'($urandom()); c = m; end
            default: begin m = 8'($urandom()); c = 8'($urandom()); end
         endcase
         wait_idle();
         csr_write(ADDR_MAGIC, m);
         csr_write(ADDR_CODE, c);
         if (phase == 2) hold_request = 1'b1;
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / 5 ||
                (phase == 4 && frames_checked < MIN_FRAMES)) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               send_frame(m, c);
               phase_items += FRAME_LEN;
            end else if (roll < 85) begin
               // header break: magic followed by magic, code or junk
               n = $urandom_range(1, 3);
               send_byte(m);
               repeat (n) begin
                  case ($urandom_range(0, 2))
                     0:       send_byte(m);
                     1:       send_byte(c);
                     default: send_byte(8'($urandom()));
                  endcase
               end
               phase_items += n + 1;
            end else begin
               repeat ($urandom_range(1, 6))
                  send_byte(($urandom_range(0, 3) == 0) ? m : 8'($urandom()));
            end
         end
      end

      wait_idle();
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
